[hdl/flh_pkg.sv]
// Shared types and constants for the fragment length histogram.
package flh_pkg;

  localparam int NUM_BINS_DEF    = 1024;
  localparam int LENGTH_BITS_DEF = 20;

  localparam int WIDTH_W = 16;
  localparam int FINAL_W = 10;
  localparam int BIN_W   = 20;
  localparam int SLOT_W  = 10;
  localparam int CNT_W   = 32;
  localparam int START_W = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register indexes, taken from paddr[2]
  localparam logic REG_BIN_WIDTH = 1'b0;
  localparam logic REG_FINAL_BIN = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic map_rd;
    logic slot_sel;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic len_zero;
    logic in_range;
    logic out_free;
  } sts_t;

endpackage

[hdl/fragment_length_histogram.sv]
// Top level of the fragment length histogram: config registers, controller, datapath.
//
//   channel  | handshake             | payload
//   in_      | in_valid / in_stall   | in_fragment_length
//   out_     | out_valid / out_stall | bin, slot, counts, start, flags, total
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// Each item runs, before the next is accepted, through the one-bit-per-cycle
// restoring divider, the registered reads of the bin map and count memories
// and the load of the output register, which waits while a held result is
// stalled; a zero length or an out-of-range bin skips the memory reads.
// After reset the bin map is swept clear entry by entry with in_stall high.
// A finished item sits in the output register while the next one is worked on.
module fragment_length_histogram #(
  parameter int NUM_BINS    = flh_pkg::NUM_BINS_DEF,
  parameter int LENGTH_BITS = flh_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [LENGTH_BITS-1:0]       in_fragment_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [flh_pkg::BIN_W-1:0]    out_bin_index,
  output logic [flh_pkg::SLOT_W-1:0]   out_slot,
  output logic [flh_pkg::CNT_W-1:0]    out_bin_count,
  output logic [flh_pkg::START_W-1:0]  out_bin_start,
  output logic                         out_is_new_bin,
  output logic                         out_is_final,
  output logic                         out_out_of_range,
  output logic [flh_pkg::CNT_W-1:0]    out_total_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flh_pkg::ADDR_W-1:0]   paddr,
  input  logic [flh_pkg::DATA_W-1:0]   pwdata,
  output logic [flh_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import flh_pkg::*;

  logic [WIDTH_W-1:0] bin_width_r;
  logic [FINAL_W-1:0] final_bin_r;
  logic               reg_sel;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r <= WIDTH_W'(1);
      final_bin_r <= '1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BIN_WIDTH: bin_width_r <= pwdata[WIDTH_W-1:0];
        REG_FINAL_BIN: final_bin_r <= pwdata[FINAL_W-1:0];
        default:       bin_width_r <= bin_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIN_WIDTH: prdata = DATA_W'(bin_width_r);
      REG_FINAL_BIN: prdata = DATA_W'(final_bin_r);
      default:       prdata = '0;
    endcase
  end

  flh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  flh_dp #(
    .NUM_BINS    (NUM_BINS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_fragment_length (in_fragment_length),
    .bin_width          (bin_width_r),
    .final_bin_index    (final_bin_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_index      (out_bin_index),
    .out_slot           (out_slot),
    .out_bin_count      (out_bin_count),
    .out_bin_start      (out_bin_start),
    .out_is_new_bin     (out_is_new_bin),
    .out_is_final       (out_is_final),
    .out_out_of_range   (out_out_of_range),
    .out_total_count    (out_total_count)
  );

endmodule

[hdl/flh_ctrl.sv]
// Sequencing state machine for the fragment length histogram.
module flh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  flh_pkg::sts_t sts,
  output flh_pkg::cmd_t cmd
);
  import flh_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RNG   = 3'd3;
  localparam logic [2:0] S_MAP   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RNG;
        end
      end
      S_RNG: begin
        // skip the table for a zero length or a bin past the end
        if (sts.len_zero || !sts.in_range) begin
          state_nxt = S_OUT;
        end else begin
          cmd.map_rd = 1'b1;
          state_nxt  = S_MAP;
        end
      end
      S_MAP: begin
        cmd.slot_sel = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/flh_dp.sv]
// Datapath: divider, bin map and count memories, totals and result register.
module flh_dp #(
  parameter int NUM_BINS    = flh_pkg::NUM_BINS_DEF,
  parameter int LENGTH_BITS = flh_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  flh_pkg::cmd_t                cmd,
  output flh_pkg::sts_t                sts,
  input  logic [LENGTH_BITS-1:0]       in_fragment_length,
  input  logic [flh_pkg::WIDTH_W-1:0]  bin_width,
  input  logic [flh_pkg::FINAL_W-1:0]  final_bin_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [flh_pkg::BIN_W-1:0]    out_bin_index,
  output logic [flh_pkg::SLOT_W-1:0]   out_slot,
  output logic [flh_pkg::CNT_W-1:0]    out_bin_count,
  output logic [flh_pkg::START_W-1:0]  out_bin_start,
  output logic                         out_is_new_bin,
  output logic                         out_is_final,
  output logic                         out_out_of_range,
  output logic [flh_pkg::CNT_W-1:0]    out_total_count
);
  import flh_pkg::*;

  localparam int SW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int UW   = $clog2(NUM_BINS + 1);
  localparam int DCW  = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;
  localparam int CMPW = ((LENGTH_BITS > UW) ? LENGTH_BITS : UW) + 1;
  localparam int EQW  = (LENGTH_BITS > FINAL_W) ? LENGTH_BITS : FINAL_W;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  logic [SW:0]      map_mem [NUM_BINS];
  logic [CNT_W-1:0] cnt_mem [NUM_BINS];

  logic [SW-1:0]          clr_addr_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   len_zero_r;
  logic [WIDTH_W-1:0]     div_w_r;
  logic [LENGTH_BITS-1:0] dvd_r;
  logic [WIDTH_W-1:0]     rem_r;
  logic [DCW-1:0]         div_cnt_r;
  logic [SW:0]            map_q_r;
  logic [CNT_W-1:0]       cnt_q_r;
  logic [SW-1:0]          slot_r;
  logic                   new_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [UW-1:0]          slots_used_r;
  logic [CNT_W-1:0]       total_r;
  logic                   out_valid_r;

  logic [WIDTH_W:0]   rem_sh;
  logic [WIDTH_W:0]   rem_diff;
  logic               rem_ge;
  logic [SW-1:0]      bin_addr;
  logic               map_hit;
  logic [SW-1:0]      slot_pick;
  logic [CNT_W-1:0]   cnt_new;
  logic               in_range;
  logic               oor;
  logic [LENGTH_BITS-1:0] bin_val;

  // one restoring step per cycle; quotient bits shift into dvd_r
  assign rem_sh   = {rem_r, dvd_r[LENGTH_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, div_w_r};
  assign rem_ge   = (rem_sh >= {1'b0, div_w_r});

  assign bin_addr  = SW'(dvd_r);
  assign in_range  = (CMPW'(dvd_r) < CMPW'(NUM_BINS));
  assign oor       = len_zero_r || !in_range;
  assign bin_val   = len_zero_r ? '0 : dvd_r;
  assign map_hit   = map_q_r[SW];
  assign slot_pick = map_hit ? map_q_r[SW-1:0] : SW'(slots_used_r);
  assign cnt_new   = new_r ? CNT_W'(1) : sat_inc(cnt_q_r);

  assign sts.clr_last = (clr_addr_r == SW'(NUM_BINS - 1));
  assign sts.div_last = (div_cnt_r == DCW'(LENGTH_BITS - 1));
  assign sts.len_zero = len_zero_r;
  assign sts.in_range = in_range;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      map_mem[clr_addr_r] <= '0;
    end else if (cmd.commit && new_r) begin
      map_mem[bin_addr] <= {1'b1, slot_r};
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[bin_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cnt_mem[slot_r] <= cnt_new;
    end
    if (cmd.slot_sel) begin
      cnt_q_r <= cnt_mem[slot_pick];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      div_cnt_r    <= '0;
      slots_used_r <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + SW'(1);
      end
      if (cmd.load) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end
      if (cmd.commit) begin
        total_r <= sat_inc(total_r);
        if (new_r && (slots_used_r < UW'(NUM_BINS))) begin
          slots_used_r <= slots_used_r + UW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r      <= in_fragment_length;
      len_zero_r <= (in_fragment_length == '0);
      dvd_r      <= in_fragment_length - LENGTH_BITS'(1);
      rem_r      <= '0;
      div_w_r    <= (bin_width == '0) ? WIDTH_W'(1) : bin_width;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[LENGTH_BITS-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[WIDTH_W-1:0] : rem_sh[WIDTH_W-1:0];
    end
    if (cmd.slot_sel) begin
      slot_r <= slot_pick;
      new_r  <= !map_hit;
    end
    if (cmd.commit) begin
      cnt_r <= cnt_new;
    end
    if (cmd.out_load) begin
      out_bin_index    <= BIN_W'(bin_val);
      out_slot         <= oor ? '0 : SLOT_W'(slot_r);
      out_bin_count    <= oor ? '0 : cnt_r;
      // first length of the bin is length minus the remainder
      out_bin_start    <= len_zero_r ? '0 : START_W'(len_r) - START_W'(rem_r);
      out_is_new_bin   <= oor ? 1'b0 : new_r;
      out_is_final     <= (EQW'(bin_val) == EQW'(final_bin_index));
      out_out_of_range <= oor;
      out_total_count  <= total_r;
    end
  end

  assign out_valid = out_valid_r;

  a_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    slots_used_r <= UW'(NUM_BINS))
    else $error("slot allocation ran past the table");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> total_r == sat_inc($past(total_r)))
    else $error("running total did not advance on a counted item");

  a_slot_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && new_r && (slots_used_r < UW'(NUM_BINS))
      |=> slots_used_r == $past(slots_used_r) + UW'(1))
    else $error("new bin did not take the next free slot");

endmodule

[tb/tb_fragment_length_histogram.sv]
// Self-checking testbench for the fragment length histogram: directed, random and backpressure runs.
`timescale 1ns / 100ps

module tb_fragment_length_histogram;
  import flh_pkg::*;

  localparam int N_BINS = NUM_BINS_DEF;
  localparam int LEN_W  = LENGTH_BITS_DEF;
  localparam int BIDX_W = $clog2(N_BINS);
  localparam int EXP_AW = 4;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [SLOT_W-1:0]  slot;
    logic [CNT_W-1:0]   bin_count;
    logic [START_W-1:0] bin_start;
    logic               is_new_bin;
    logic               is_final;
    logic               out_of_range;
    logic [CNT_W-1:0]   total_count;
  } bin_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [LEN_W-1:0]    in_fragment_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BIN_W-1:0]    out_bin_index;
  logic [SLOT_W-1:0]   out_slot;
  logic [CNT_W-1:0]    out_bin_count;
  logic [START_W-1:0]  out_bin_start;
  logic                out_is_new_bin;
  logic                out_is_final;
  logic                out_out_of_range;
  logic [CNT_W-1:0]    out_total_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  fragment_length_histogram dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_fragment_length (in_fragment_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_index      (out_bin_index),
    .out_slot           (out_slot),
    .out_bin_count      (out_bin_count),
    .out_bin_start      (out_bin_start),
    .out_is_new_bin     (out_is_new_bin),
    .out_is_final       (out_is_final),
    .out_out_of_range   (out_out_of_range),
    .out_total_count    (out_total_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Histogram state as the block should hold it
  logic [WIDTH_W-1:0]  bin_width_set;
  logic [FINAL_W-1:0]  final_bin_set;
  bit                  bin_mapped [N_BINS];
  logic [SLOT_W-1:0]   bin_slot [N_BINS];
  logic [CNT_W-1:0]    slot_tally [N_BINS];
  logic [SLOT_W:0]     slots_taken;
  logic [CNT_W-1:0]    lengths_counted;

  // Ring of expected results, oldest at exp_head
  bin_result_t         expected_bins [2**EXP_AW];
  logic [EXP_AW:0]     exp_head;
  logic [EXP_AW:0]     exp_tail;

  int unsigned mismatches;
  int unsigned lengths_sent;
  int unsigned results_checked;
  int unsigned bins_opened;
  int unsigned lengths_dropped;
  int unsigned widths_used;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold_left;
  int unsigned sink_burst_left;

  function automatic logic [CNT_W-1:0] sat_add1(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Bin one length and update the histogram; returns the result it must produce
  function automatic bin_result_t count_length(input logic [LEN_W-1:0] len);
    bin_result_t r;
    logic [63:0] w_eff;
    logic [63:0] bin64;
    logic [63:0] start64;
    logic [SLOT_W-1:0] s;
    logic [BIDX_W-1:0] b;
    r = '0;
    w_eff = (bin_width_set == '0) ? 64'd1 : 64'(bin_width_set);
    if (len == '0) begin
      r.out_of_range = 1'b1;
      r.is_final = (final_bin_set == '0);
      lengths_dropped++;
    end else begin
      bin64 = (64'(len) - 64'd1) / w_eff;
      start64 = bin64 * w_eff + 64'd1;
      r.bin_index = bin64[BIN_W-1:0];
      r.bin_start = start64[START_W-1:0];
      r.is_final = (bin64 == 64'(final_bin_set));
      if (bin64 >= 64'(N_BINS)) begin
        r.out_of_range = 1'b1;
        lengths_dropped++;
      end else begin
        b = bin64[BIDX_W-1:0];
        if (bin_mapped[b]) begin
          s = bin_slot[b];
          slot_tally[s] = sat_add1(slot_tally[s]);
        end else begin
          s = SLOT_W'(slots_taken % N_BINS);
          bin_mapped[b] = 1'b1;
          bin_slot[b] = s;
          slot_tally[s] = CNT_W'(1);
          if (slots_taken < N_BINS) slots_taken++;
          r.is_new_bin = 1'b1;
          bins_opened++;
        end
        r.slot = s;
        r.bin_count = slot_tally[s];
        lengths_counted = sat_add1(lengths_counted);
      end
    end
    r.total_count = lengths_counted;
    return r;
  endfunction

  // Mostly lengths that land in the table, near bin edges, plus zeros and raw noise
  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned roll;
    int unsigned w;
    logic [63:0] bin64;
    logic [63:0] len64;
    roll = $urandom_range(0, 99);
    w = (bin_width_set == '0) ? 1 : int'(bin_width_set);
    if (roll < 5) return '0;
    if (roll < 15) return LEN_W'($urandom);
    bin64 = (roll < 55) ? 64'($urandom_range(0, 31)) : 64'($urandom_range(0, N_BINS - 1));
    case (roll % 3)
      0: len64 = bin64 * w + 1;
      1: len64 = bin64 * w + w;
      default: len64 = bin64 * w + 1 + 64'($urandom_range(0, w - 1));
    endcase
    if (len64 > 64'({LEN_W{1'b1}})) return LEN_W'($urandom);
    return len64[LEN_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    bin_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_head == exp_tail) begin
        $error("result with no item pending: bin_index %0d", out_bin_index);
        mismatches++;
      end else begin
        e = expected_bins[exp_head[EXP_AW-1:0]];
        exp_head = exp_head + (EXP_AW + 1)'(1);
        check_field("bin_index", 64'(e.bin_index), 64'(out_bin_index));
        check_field("slot", 64'(e.slot), 64'(out_slot));
        check_field("bin_count", 64'(e.bin_count), 64'(out_bin_count));
        check_field("bin_start", 64'(e.bin_start), 64'(out_bin_start));
        check_field("is_new_bin", 64'(e.is_new_bin), 64'(out_is_new_bin));
        check_field("is_final", 64'(e.is_final), 64'(out_is_final));
        check_field("out_of_range", 64'(e.out_of_range), 64'(out_out_of_range));
        check_field("total_count", 64'(e.total_count), 64'(out_total_count));
        results_checked++;
      end
    end
  end

  // Receiver: long hold when asked, otherwise random stall bursts
  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_stall <= 1'b1;
    end else if (sink_burst_left > 0) begin
      sink_burst_left--;
      out_stall <= 1'b1;
    end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      sink_burst_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_length(input logic [LEN_W-1:0] len);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_fragment_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_bins[exp_tail[EXP_AW-1:0]] = count_length(len);
    exp_tail = exp_tail + (EXP_AW + 1)'(1);
    lengths_sent++;
    @(negedge clk);
  endtask

  task automatic stop_items();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_head != exp_tail) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == REG_BIN_WIDTH) bin_width_set = value[WIDTH_W-1:0];
    else final_bin_set = value[FINAL_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // leave the bus idle before returning so the next write does not collide with this one
    @(negedge clk);
  endtask

  task automatic set_bins(input logic [WIDTH_W-1:0] w, input logic [FINAL_W-1:0] fb);
    write_reg(REG_BIN_WIDTH, {16'($urandom_range(0, 65535)), w});
    write_reg(REG_FINAL_BIN, {22'($urandom_range(0, 4194303)), fb});
    widths_used++;
  endtask

  // Reset values: unit bins, last table bin flagged final
  task automatic test_default_bins();
    send_length(1);
    send_length(1);
    send_length(0);
    send_length(1024);
    send_length(1025);
    send_length({LEN_W{1'b1}});
    send_length(2);
    send_length(20'h80000);
    stop_items();
  endtask

  // Width zero acts as one; final bin zero also flags zero lengths
  task automatic test_zero_width();
    wait_drained();
    set_bins(16'd0, 10'd0);
    send_length(0);
    send_length(1);
    send_length(5);
    send_length(1024);
    send_length(1025);
    stop_items();
  endtask

  task automatic test_widest_bins();
    wait_drained();
    set_bins(16'hFFFF, 10'd16);
    send_length({LEN_W{1'b1}});
    send_length(65535);
    send_length(65536);
    send_length(1);
    send_length(20'h55555);
    send_length(20'hAAAAA);
    stop_items();
  endtask

  task automatic test_random_widths();
    logic [WIDTH_W-1:0] w;
    logic [FINAL_W-1:0] fb;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: w = 16'd1;
        1: w = 16'hFFFF;
        2: w = 16'd0;
        3: w = WIDTH_W'($urandom_range(2, 16));
        4: w = WIDTH_W'($urandom_range(17, 1200));
        default: w = WIDTH_W'($urandom_range(1, 65535));
      endcase
      fb = (ph == 0) ? 10'd1023 : (ph == 2) ? 10'd0 : FINAL_W'($urandom_range(0, 1023));
      set_bins(w, fb);
      src_idle_pct = (ph == 3) ? 0 : $urandom_range(5, 35);
      sink_idle_pct = (ph == 4) ? 0 : $urandom_range(5, 35);
      repeat (150) send_length(pick_length());
      stop_items();
    end
  endtask

  // Hold the receiver off while items keep coming, so the input backs up
  task automatic test_backpressure();
    wait_drained();
    set_bins(WIDTH_W'($urandom_range(1, 8)), FINAL_W'($urandom_range(0, 31)));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sink_hold_left = 400;
    repeat (40) send_length(pick_length());
    stop_items();
  endtask

  task automatic test_steady_stream();
    wait_drained();
    set_bins(WIDTH_W'($urandom_range(1, 300)), FINAL_W'($urandom_range(0, 1023)));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (100) send_length(pick_length());
    stop_items();
  endtask

  initial begin
    bin_width_set = 16'd1;
    final_bin_set = 10'd1023;
    slots_taken = '0;
    lengths_counted = '0;
    exp_head = '0;
    exp_tail = '0;
    foreach (bin_mapped[i]) bin_mapped[i] = 1'b0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sink_hold_left = 0;
    sink_burst_left = 0;
    widths_used = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_default_bins();
    test_zero_width();
    test_widest_bins();
    test_random_widths();
    test_backpressure();
    test_steady_stream();

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Sent %0d lengths over %0d bin settings, checked %0d results.",
             lengths_sent, widths_used, results_checked);
    $display("Bins opened: %0d, lengths left uncounted: %0d.", bins_opened, lengths_dropped);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hdl/flh_pkg.sv
hdl/flh_ctrl.sv
hdl/flh_dp.sv
hdl/fragment_length_histogram.sv
tb/tb_fragment_length_histogram.sv
